// ===== rtl/fcc_pkg.sv =====
// Shared types, constants and the opcode length table for the floppy
// controller command/result core. No dependencies.
package fcc_pkg;

  // Result queue sizing
  localparam int RESULT_DEPTH = 16;
  localparam int QA_W         = $clog2(RESULT_DEPTH);
  localparam int QC_W         = $clog2(RESULT_DEPTH + 1);

  // Main status bits
  localparam int MSR_RQM_BIT = 7;
  localparam int MSR_DIO_BIT = 6;
  localparam int MSR_EXM_BIT = 5;
  localparam int MSR_CB_BIT  = 4;
  localparam logic [7:0] MSR_RESET = 8'h80;

  // Status register zero
  localparam int SR0_SE_BIT = 5;
  localparam int SR0_NR_BIT = 3;
  localparam logic [7:0] SR0_RESET   = 8'h08;
  localparam logic [1:0] SR0_IC_NONE = 2'b00;
  localparam logic [1:0] SR0_IC_INV  = 2'b10;

  // Opcodes that do real work here
  localparam logic [4:0] OP_SENSE_DRIVE = 5'h04;
  localparam logic [4:0] OP_RECAL       = 5'h07;
  localparam logic [4:0] OP_SENSE_INT   = 5'h08;
  localparam logic [4:0] OP_SEEK        = 5'h0f;

  // Opcodes that only take their parameter bytes
  localparam logic [4:0] OP_READ_TRACK  = 5'h02;
  localparam logic [4:0] OP_SPECIFY     = 5'h03;
  localparam logic [4:0] OP_WRITE_DATA  = 5'h05;
  localparam logic [4:0] OP_READ_DATA   = 5'h06;
  localparam logic [4:0] OP_WRITE_DEL   = 5'h09;
  localparam logic [4:0] OP_READ_ID     = 5'h0a;
  localparam logic [4:0] OP_READ_DEL    = 5'h0c;
  localparam logic [4:0] OP_FORMAT      = 5'h0d;
  localparam logic [4:0] OP_SCAN_EQ     = 5'h11;
  localparam logic [4:0] OP_SCAN_LE     = 5'h19;
  localparam logic [4:0] OP_SCAN_HE     = 5'h1d;

  typedef enum logic [1:0] {
    MODE_WRITE     = 2'd0,
    MODE_READ_DATA = 2'd1,
    MODE_READ_MSR  = 2'd2,
    MODE_IGNORE    = 2'd3
  } fcc_mode_t;

  typedef enum logic [0:0] {
    CFG_DISK_PRESENT = 1'b0,
    CFG_SINGLE_SIDED = 1'b1
  } fcc_cfg_idx_t;

  typedef struct packed {
    fcc_mode_t   mode;
    logic [7:0]  data_byte;
  } fcc_in_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       command_rejected;
    logic       command_executed;
  } fcc_out_t;

  typedef struct packed {
    logic         en;
    fcc_cfg_idx_t index;
    logic         data;
  } fcc_cfg_wr_t;

  typedef struct packed {
    logic       push0;
    logic [7:0] data0;
    logic       push1;
    logic [7:0] data1;
  } fcc_push_t;

  typedef struct packed {
    logic       empty;
    logic       last;
    logic [7:0] head_data;
  } fcc_q_stat_t;

  typedef struct packed {
    logic       known;
    logic [3:0] len;
  } fcc_plen_t;

  // Parameter byte count per opcode
  function automatic fcc_plen_t param_len(input logic [4:0] op);
    fcc_plen_t r;
    r.known = 1'b1;
    case (op)
      OP_READ_TRACK:  r.len = 4'd8;
      OP_SPECIFY:     r.len = 4'd2;
      OP_SENSE_DRIVE: r.len = 4'd1;
      OP_WRITE_DATA:  r.len = 4'd8;
      OP_READ_DATA:   r.len = 4'd8;
      OP_RECAL:       r.len = 4'd1;
      OP_SENSE_INT:   r.len = 4'd0;
      OP_WRITE_DEL:   r.len = 4'd8;
      OP_READ_ID:     r.len = 4'd1;
      OP_READ_DEL:    r.len = 4'd8;
      OP_FORMAT:      r.len = 4'd5;
      OP_SEEK:        r.len = 4'd2;
      OP_SCAN_EQ:     r.len = 4'd8;
      OP_SCAN_LE:     r.len = 4'd8;
      OP_SCAN_HE:     r.len = 4'd8;
      default: begin
        r.known = 1'b0;
        r.len   = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/fcc_result_queue.sv =====
// Result byte FIFO: up to two pushes or one pop per cycle, full pushes dropped.
// Depends on fcc_pkg.
module fcc_result_queue
  import fcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fcc_push_t   push,
  input  logic        pop,
  output fcc_q_stat_t stat
);

  localparam logic [QC_W:0]   DEPTH_W = (QC_W + 1)'(RESULT_DEPTH);
  localparam logic [QA_W-1:0] LAST_IDX = QA_W'(RESULT_DEPTH - 1);

  logic [7:0]      mem_r [RESULT_DEPTH];
  logic [QA_W-1:0] head_r, head_nxt;
  logic [QC_W-1:0] count_r, count_nxt;

  logic [QC_W:0]   sum0, sum1, cnt_ext;
  logic [QA_W-1:0] wa0, wa1;
  logic            p0, p1;

  always_comb begin
    cnt_ext = {1'b0, count_r};
    sum0    = (QC_W + 1)'(head_r) + cnt_ext;
    sum1    = sum0 + 1'b1;
    wa0     = (sum0 >= DEPTH_W) ? QA_W'(sum0 - DEPTH_W) : QA_W'(sum0);
    wa1     = (sum1 >= DEPTH_W) ? QA_W'(sum1 - DEPTH_W) : QA_W'(sum1);
    p0      = push.push0 && (cnt_ext < DEPTH_W);
    p1      = push.push1 && p0 && ((cnt_ext + 1'b1) < DEPTH_W);

    head_nxt  = head_r;
    count_nxt = count_r;
    if (pop) begin
      head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r + QC_W'(p0) + QC_W'(p1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p0) begin
      mem_r[wa0] <= push.data0;
    end
    if (p1) begin
      mem_r[wa1] <= push.data1;
    end
  end

  assign stat.empty     = (count_r == '0);
  assign stat.last      = (count_r == QC_W'(1));
  assign stat.head_data = mem_r[head_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QC_W'(RESULT_DEPTH))
    else $error("result queue count overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty result queue");

endmodule

// ===== rtl/fcc_cmd_unit.sv =====
// Command collection, opcode decode, execution and status registers.
// Depends on fcc_pkg; drives the result queue push/pop.
module fcc_cmd_unit
  import fcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  fcc_in_t     item,
  input  fcc_cfg_wr_t cfg,
  input  fcc_q_stat_t qstat,
  output fcc_push_t   push,
  output logic        pop,
  output fcc_out_t    res
);

  logic [3:0] cnt_r, cnt_nxt;
  logic [4:0] opcode_r, opcode_nxt;
  logic [7:0] msr_r, msr_nxt;
  logic [7:0] sr0_r, sr0_nxt;
  logic [7:0] cyl_r, cyl_nxt;
  logic       t0_r, t0_nxt;
  logic       dp_r, dp_nxt;
  logic       ss_r, ss_nxt;

  logic [4:0] op;
  fcc_plen_t  plen;
  logic [3:0] cnt_inc;
  logic [7:0] s3;
  logic [7:0] sr0_seek;

  always_comb begin
    cnt_nxt    = cnt_r;
    opcode_nxt = opcode_r;
    msr_nxt    = msr_r;
    sr0_nxt    = sr0_r;
    cyl_nxt    = cyl_r;
    t0_nxt     = t0_r;
    dp_nxt     = dp_r;
    ss_nxt     = ss_r;
    push       = '0;
    pop        = 1'b0;
    res        = '0;

    op       = (cnt_r == 4'd0) ? item.data_byte[4:0] : opcode_r;
    plen     = param_len(op);
    cnt_inc  = cnt_r + 4'd1;
    s3       = {2'b00, dp_r, t0_r, dp_r & ss_r, 3'b000};
    sr0_seek = {SR0_IC_NONE, 1'b1, sr0_r[4:0]};

    if (en) begin
      case (item.mode)
        MODE_WRITE: begin
          if (cnt_r == 4'd0) begin
            opcode_nxt = item.data_byte[4:0];
          end
          cnt_nxt = cnt_inc;
          if (!plen.known) begin
            cnt_nxt = 4'd0;
            res.command_rejected = 1'b1;
          end else if ((plen.len + 4'd1) == cnt_inc) begin
            cnt_nxt = 4'd0;
            res.command_executed = 1'b1;
            msr_nxt[MSR_CB_BIT] = 1'b1;
            case (op)
              OP_SENSE_DRIVE: begin
                msr_nxt[MSR_DIO_BIT] = 1'b1;
                push.push0 = 1'b1;
                push.data0 = s3;
              end
              OP_RECAL: begin
                cyl_nxt = 8'd0;
                t0_nxt  = 1'b1;
                sr0_nxt = sr0_seek;
              end
              OP_SENSE_INT: begin
                msr_nxt[MSR_DIO_BIT] = 1'b1;
                push.push0 = 1'b1;
                push.data0 = sr0_r;
                push.push1 = 1'b1;
                push.data1 = cyl_r;
                sr0_nxt = {SR0_IC_INV, sr0_r[5:0]};
              end
              OP_SEEK: begin
                // third byte is the one arriving now
                cyl_nxt = item.data_byte;
                t0_nxt  = (item.data_byte == 8'd0);
                sr0_nxt = sr0_seek;
              end
              default: ;
            endcase
          end
        end
        MODE_READ_DATA: begin
          if (msr_r[MSR_DIO_BIT]) begin
            if (!qstat.empty) begin
              res.read_value = qstat.head_data;
              pop = 1'b1;
            end
            if (qstat.empty || qstat.last) begin
              msr_nxt[MSR_DIO_BIT] = 1'b0;
              msr_nxt[MSR_CB_BIT]  = 1'b0;
              msr_nxt[MSR_EXM_BIT] = 1'b0;
            end
          end
        end
        MODE_READ_MSR: begin
          res.read_value = msr_r;
        end
        default: ;
      endcase
    end

    if (cfg.en) begin
      case (cfg.index)
        CFG_DISK_PRESENT: begin
          dp_nxt = cfg.data;
          sr0_nxt[SR0_NR_BIT] = ~cfg.data;
        end
        CFG_SINGLE_SIDED: ss_nxt = cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      msr_r <= MSR_RESET;
      sr0_r <= SR0_RESET;
      cyl_r <= 8'd0;
      t0_r  <= 1'b0;
      dp_r  <= 1'b0;
      ss_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      msr_r <= msr_nxt;
      sr0_r <= sr0_nxt;
      cyl_r <= cyl_nxt;
      t0_r  <= t0_nxt;
      dp_r  <= dp_nxt;
      ss_r  <= ss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opcode_r <= opcode_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'd8)
    else $error("command byte count out of range");

  a_rqm_set: assert property (@(posedge clk) disable iff (!rst_n)
    msr_r[MSR_RQM_BIT])
    else $error("request-for-master bit lost");

endmodule

// ===== rtl/floppy_controller_command_result_core.sv =====
// Floppy controller command/result core: input register, command unit,
// result FIFO, result register. Depends on fcc_pkg and its submodules.
// Result path: input transaction through the input reg, then the result reg.
// Throughput: one bus access per cycle unless the result channel stalls; the
//   command unit updates all state in one pass between the two registers.
// Reset: synchronous active-low rst_n clears control/status; FIFO storage
//   and command byte storage are not cleared. No clearing pass.
module floppy_controller_command_result_core
  import fcc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_valid,
  output logic         in_stall,
  input  fcc_in_t      in_data,
  // result channel
  output logic         out_valid,
  input  logic         out_stall,
  output fcc_out_t     out_data,
  // config writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  fcc_cfg_idx_t cfg_index,
  input  logic         cfg_data
);

  // stage 1: captured bus access
  logic        s1_v_r, s1_v_nxt;
  fcc_in_t     s1_item_r;
  // stage 2: result register
  logic        out_v_r, out_v_nxt;
  fcc_out_t    out_data_r;

  logic        out_free;   // result register can take a new transaction
  logic        s1_adv;     // stage 1 item executes this cycle
  logic        in_acc;

  fcc_cfg_wr_t cfg_wr;
  fcc_push_t   q_push;
  logic        q_pop;
  fcc_q_stat_t q_stat;
  fcc_out_t    res;

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_acc   = in_valid && !in_stall;

  // config regs always writable; user must only write when idle (unchecked)
  assign cfg_ready    = 1'b1;
  assign cfg_wr.en    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    out_v_nxt = s1_adv ? 1'b1 : (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  // decode, execute, status update; state moves only on s1_adv or a config write
  fcc_cmd_unit u_cmd (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (s1_adv),
    .item  (s1_item_r),
    .cfg   (cfg_wr),
    .qstat (q_stat),
    .push  (q_push),
    .pop   (q_pop),
    .res   (res)
  );

  // result bytes waiting for data reads
  fcc_result_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .stat  (q_stat)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  // queue is pushed or popped only by an executing stage 1 item
  a_adv_room: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop || q_push.push0) |-> s1_adv)
    else $error("queue touched without an executing transaction");

endmodule

// ===== tb/sv/floppy_controller_command_result_core_tb.sv =====
// Self-checking testbench for floppy_controller_command_result_core: directed and
// random bus accesses with a cycle-free predictor of the command/result phase.
// Depends on fcc_pkg and the core RTL only.
module floppy_controller_command_result_core_tb;
  import fcc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // An opcode the chip does not know
  localparam logic [4:0] NO_SUCH_OP     = 5'h1f;

  // Drive status (status register three) bits
  localparam int ST3_TS_BIT = 3;
  localparam int ST3_T0_BIT = 4;
  localparam int ST3_RY_BIT = 5;

  localparam int MAX_IDLE     = 14;
  localparam int SETTLE_TICKS = 4;
  localparam int PHASE_ITEMS  = 100;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  fcc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fcc_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  fcc_cfg_idx_t cfg_index = CFG_DISK_PRESENT;
  logic     cfg_data = 1'b0;

  floppy_controller_command_result_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Bus accesses waiting for the driver, and the replies they must produce
  fcc_in_t  bus_accesses[$];
  fcc_out_t predicted_replies[$];

  int error_count = 0;
  int accesses_done = 0;
  int cmds_executed = 0;
  int cmds_rejected = 0;
  int pushes_dropped = 0;
  int phases_run = 0;

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller: command buffer, result FIFO, status regs
  // ---------------------------------------------------------------------------
  logic [7:0] cmd_buf [9];
  int         cmd_fill = 0;
  logic [7:0] result_fifo [RESULT_DEPTH];
  int         fifo_head = 0;
  int         fifo_fill = 0;
  logic [7:0] msr_q = MSR_RESET;
  logic [7:0] sr0_q = SR0_RESET;
  logic [7:0] st3_q = 8'h00;     // only track-zero is ever stored
  logic [7:0] cyl_q = 8'h00;
  logic       disk_q = 1'b0;
  logic       single_q = 1'b0;

  // Parameter bytes after the opcode byte; -1 for an opcode the chip rejects
  function automatic int cmd_param_count(logic [4:0] op);
    case (op)
      OP_READ_TRACK, OP_WRITE_DATA, OP_READ_DATA, OP_WRITE_DEL,
      OP_READ_DEL, OP_SCAN_EQ, OP_SCAN_LE, OP_SCAN_HE: return 8;
      OP_FORMAT:                                       return 5;
      OP_SPECIFY, OP_SEEK:                             return 2;
      OP_SENSE_DRIVE, OP_RECAL, OP_READ_ID:            return 1;
      OP_SENSE_INT:                                    return 0;
      default:                                         return -1;
    endcase
  endfunction

  // A push onto a full FIFO is lost
  function automatic void push_result_byte(logic [7:0] b);
    if (fifo_fill >= RESULT_DEPTH) begin
      pushes_dropped++;
    end else begin
      result_fifo[(fifo_head + fifo_fill) % RESULT_DEPTH] = b;
      fifo_fill++;
    end
  endfunction

  // Advances the shadow state by one bus access and returns the reply
  function automatic fcc_out_t apply_bus_access(fcc_in_t acc);
    fcc_out_t   r;
    logic [4:0] op;
    logic [7:0] st3;
    int         plen;
    r = '0;
    case (acc.mode)
      MODE_WRITE: begin
        if (cmd_fill < 9) begin
          cmd_buf[cmd_fill] = acc.data_byte;
          cmd_fill++;
        end
        op   = cmd_buf[0][4:0];
        plen = cmd_param_count(op);
        if (plen < 0) begin
          // only a first byte can land here; the buffer is dropped
          cmd_fill = 0;
          r.command_rejected = 1'b1;
          cmds_rejected++;
        end else if (plen + 1 == cmd_fill) begin
          msr_q[MSR_CB_BIT] = 1'b1;
          case (op)
            OP_SENSE_DRIVE: begin
              st3 = st3_q;
              if (disk_q) begin
                st3[ST3_RY_BIT] = 1'b1;
                if (single_q) st3[ST3_TS_BIT] = 1'b1;
              end
              msr_q[MSR_DIO_BIT] = 1'b1;
              push_result_byte(st3);
            end
            OP_RECAL: begin
              cyl_q = 8'h00;
              st3_q[ST3_T0_BIT] = 1'b1;
              sr0_q[SR0_SE_BIT] = 1'b1;
              sr0_q[7:6] = SR0_IC_NONE;
            end
            OP_SENSE_INT: begin
              msr_q[MSR_DIO_BIT] = 1'b1;
              push_result_byte(sr0_q);
              push_result_byte(cyl_q);
              sr0_q[7:6] = SR0_IC_INV;
            end
            OP_SEEK: begin
              cyl_q = cmd_buf[2];
              st3_q[ST3_T0_BIT] = (cyl_q == 8'h00);
              sr0_q[SR0_SE_BIT] = 1'b1;
              sr0_q[7:6] = SR0_IC_NONE;
            end
            default: ;  // sector commands: busy only
          endcase
          cmd_fill = 0;
          r.command_executed = 1'b1;
          cmds_executed++;
        end
      end
      MODE_READ_DATA: begin
        // without the direction bit the read is a no-op returning zero
        if (msr_q[MSR_DIO_BIT]) begin
          if (fifo_fill > 0) begin
            r.read_value = result_fifo[fifo_head];
            fifo_head = (fifo_head + 1) % RESULT_DEPTH;
            fifo_fill--;
          end
          if (fifo_fill == 0) begin
            msr_q[MSR_DIO_BIT] = 1'b0;
            msr_q[MSR_CB_BIT]  = 1'b0;
            msr_q[MSR_EXM_BIT] = 1'b0;
          end
        end
      end
      MODE_READ_MSR: r.read_value = msr_q;
      default: ;  // mode three: ignored, all-zero reply
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one transaction at a time from bus_accesses, random gaps between
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  bit sender_no_idle = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_replies = {predicted_replies, apply_bus_access(in_data)};
        accesses_done++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction as it is
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (bus_accesses.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= bus_accesses.pop_front();
        if ($urandom_range(0, 31) == 0) sender_no_idle = !sender_no_idle;
        gap_left = sender_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every reply with the oldest prediction, stall at random
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit receiver_no_idle = 1'b0;

  always @(posedge clk) begin
    fcc_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected reply, actual %p", $time, out_data);
          error_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_data.read_value !== want.read_value) begin
            $display("%0t: read_value expected %02h actual %02h",
                     $time, want.read_value, out_data.read_value);
            error_count++;
          end
          if (out_data.command_rejected !== want.command_rejected) begin
            $display("%0t: command_rejected expected %b actual %b",
                     $time, want.command_rejected, out_data.command_rejected);
            error_count++;
          end
          if (out_data.command_executed !== want.command_executed) begin
            $display("%0t: command_executed expected %b actual %b",
                     $time, want.command_executed, out_data.command_executed);
            error_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) receiver_no_idle = !receiver_no_idle;
        stall_left = receiver_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void add_access(fcc_mode_t m, logic [7:0] b);
    fcc_in_t a;
    a.mode      = m;
    a.data_byte = b;
    bus_accesses = {bus_accesses, a};
  endfunction

  // Config is only touched while the core is idle
  task automatic write_setting(fcc_cfg_idx_t idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DISK_PRESENT) begin
      disk_q = val;
      sr0_q[SR0_NR_BIT] = !val;
    end else begin
      single_q = val;
    end
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued access is sent and every predicted reply is back,
  // then let the pipeline settle
  task automatic drain_core();
    do @(negedge clk);
    while (bus_accesses.size() != 0 || in_valid || predicted_replies.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic queue_directed_accesses();
    add_access(MODE_READ_MSR, 8'h00);
    add_access(MODE_READ_DATA, 8'hff);             // direction bit clear
    add_access(MODE_IGNORE, 8'hff);
    add_access(MODE_WRITE, {3'b111, NO_SUCH_OP});  // unknown opcode
    add_access(MODE_WRITE, {3'b000, OP_SENSE_INT});
    add_access(MODE_READ_MSR, 8'h00);
    add_access(MODE_READ_DATA, 8'h00);
    add_access(MODE_READ_DATA, 8'h00);
    add_access(MODE_READ_DATA, 8'h00);             // queue already drained
    add_access(MODE_WRITE, {3'b000, OP_SEEK});     // seek to top cylinder
    add_access(MODE_WRITE, 8'h00);
    add_access(MODE_WRITE, 8'hff);
    add_access(MODE_WRITE, {3'b111, OP_SENSE_DRIVE});
    add_access(MODE_WRITE, 8'h01);
    add_access(MODE_READ_MSR, 8'h00);
    add_access(MODE_READ_DATA, 8'h00);
    add_access(MODE_WRITE, {3'b000, OP_RECAL});
    add_access(MODE_WRITE, 8'h00);
    add_access(MODE_WRITE, {3'b000, OP_SENSE_INT});
    add_access(MODE_READ_DATA, 8'h00);
    add_access(MODE_READ_DATA, 8'h00);
    add_access(MODE_WRITE, {3'b000, OP_SEEK});     // seek back to zero
    add_access(MODE_WRITE, 8'h00);
    add_access(MODE_WRITE, 8'h00);
    add_access(MODE_READ_MSR, 8'h00);
  endtask

  // Mostly complete commands with random content and the reads they call for;
  // the rest is sense-interrupt bursts that can overflow the FIFO, noise and
  // truncated or unknown commands.
  task automatic queue_random_traffic(int n);
    logic [4:0] real_ops [4];
    logic [4:0] all_ops [15];
    logic [4:0] op;
    logic [7:0] b;
    int start, kind, plen, nreads, burst;
    real_ops = '{OP_SENSE_DRIVE, OP_RECAL, OP_SENSE_INT, OP_SEEK};
    all_ops  = '{OP_READ_TRACK, OP_SPECIFY, OP_SENSE_DRIVE, OP_WRITE_DATA,
                 OP_READ_DATA, OP_RECAL, OP_SENSE_INT, OP_WRITE_DEL, OP_READ_ID,
                 OP_READ_DEL, OP_FORMAT, OP_SEEK, OP_SCAN_EQ, OP_SCAN_LE,
                 OP_SCAN_HE};
    start = bus_accesses.size();
    while (bus_accesses.size() - start < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        if ($urandom_range(0, 9) < 7) op = real_ops[$urandom_range(0, 3)];
        else op = all_ops[$urandom_range(0, 14)];
        plen = cmd_param_count(op);
        add_access(MODE_WRITE, {3'($urandom), op});
        for (int i = 1; i <= plen; i++) begin
          b = 8'($urandom);
          if (op == OP_SEEK && i == 2 && $urandom_range(0, 3) == 0) b = 8'h00;
          add_access(MODE_WRITE, b);
        end
        nreads = (op == OP_SENSE_INT) ? 2 : (op == OP_SENSE_DRIVE) ? 1 : 0;
        nreads += $urandom_range(0, 1);
        if ($urandom_range(0, 1)) add_access(MODE_READ_MSR, 8'($urandom));
        repeat (nreads) add_access(MODE_READ_DATA, 8'($urandom));
      end else if (kind < 70) begin
        // several sense interrupts back to back can push past the FIFO depth
        burst = $urandom_range(2, 11);
        repeat (burst) add_access(MODE_WRITE, {3'($urandom), OP_SENSE_INT});
        add_access(MODE_READ_MSR, 8'($urandom));
        repeat (2 * burst + $urandom_range(0, 2))
          add_access(MODE_READ_DATA, 8'($urandom));
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 4))
          add_access(fcc_mode_t'($urandom_range(0, 3)), 8'($urandom));
      end else if (kind < 95) begin
        do op = 5'($urandom); while (cmd_param_count(op) >= 0);
        add_access(MODE_WRITE, {3'($urandom), op});
      end else begin
        // command cut short; following bytes fill its parameters
        op = all_ops[$urandom_range(0, 14)];
        add_access(MODE_WRITE, {3'($urandom), op});
        if (cmd_param_count(op) > 1)
          repeat ($urandom_range(0, cmd_param_count(op) - 1))
            add_access(MODE_WRITE, 8'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed pass at reset settings, then random phases
  // under each disk setting and finally random settings
  // ---------------------------------------------------------------------------
  initial begin
    logic disk_sel [5];
    logic side_sel [5];
    disk_sel = '{1'b1, 1'b1, 1'b0, 1'b0, 1'($urandom)};
    side_sel = '{1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom)};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    queue_directed_accesses();
    drain_core();

    for (int p = 0; p < 5; p++) begin
      if ($urandom_range(0, 1)) begin
        write_setting(CFG_DISK_PRESENT, disk_sel[p]);
        write_setting(CFG_SINGLE_SIDED, side_sel[p]);
      end else begin
        write_setting(CFG_SINGLE_SIDED, side_sel[p]);
        write_setting(CFG_DISK_PRESENT, disk_sel[p]);
      end
      queue_random_traffic(PHASE_ITEMS);
      drain_core();
      phases_run++;
    end

    $display("Ran %0d bus accesses over %0d setting phases plus a directed pass;",
             accesses_done, phases_run);
    $display("%0d commands executed, %0d rejected, %0d result pushes lost to a full FIFO.",
             cmds_executed, cmds_rejected, pushes_dropped);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("Timeout with %0d replies outstanding", predicted_replies.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== floppy_controller_command_result_core.f =====
rtl/fcc_pkg.sv
rtl/fcc_result_queue.sv
rtl/fcc_cmd_unit.sv
rtl/floppy_controller_command_result_core.sv
tb/sv/floppy_controller_command_result_core_tb.sv
